// ----- rtl/u16450_pkg.sv -----
package u16450_pkg;

    // Register offsets inside the eight-port window
    localparam logic [2:0] OFF_RBR_THR = 3'd0;
    localparam logic [2:0] OFF_IER     = 3'd1;
    localparam logic [2:0] OFF_IIR     = 3'd2;
    localparam logic [2:0] OFF_LCR     = 3'd3;
    localparam logic [2:0] OFF_MCR     = 3'd4;
    localparam logic [2:0] OFF_LSR     = 3'd5;
    localparam logic [2:0] OFF_MSR     = 3'd6;
    localparam logic [2:0] OFF_SCR     = 3'd7;

    localparam int unsigned DLAB_POS = 7;
    localparam int unsigned IER_THRE_POS = 1;
    localparam logic [1:0] IIR_NONE = 2'b01;
    localparam logic [1:0] IIR_THRE = 2'b10;
    localparam logic [7:0] LSR_IDLE = 8'h60;
    localparam logic [15:0] BASE_PORT_RST = 16'd1016;

    typedef struct packed {
        logic       is_write;
        logic [15:0] port;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_level;
        logic       irq_changed;
        logic       bad_access;
    } rsp_t;

    typedef struct packed {
        logic [7:0] divisor_low;
        logic [7:0] divisor_high;
        logic [3:0] int_enable;
        logic [1:0] int_ident;
        logic [7:0] line_ctrl;
        logic [4:0] modem_ctrl;
        logic [7:0] scratch;
        logic       irq_pending;
    } uart_state_t;

endpackage

// ----- rtl/u16450_access.sv -----
module u16450_access (
    input  u16450_pkg::req_t        req,
    input  logic [15:0]             base_port,
    input  u16450_pkg::uart_state_t state,
    output u16450_pkg::uart_state_t state_next,
    output u16450_pkg::rsp_t        rsp
);

    logic [16:0] diff;
    logic        in_window;
    logic [2:0]  offset;
    logic        dlab;
    logic [7:0]  rd;
    logic        txv;
    logic [7:0]  txb;
    u16450_pkg::uart_state_t st_w;
    logic        pend_n;
    logic        chg;

    // Window check: no borrow and offset below eight
    assign diff      = {1'b0, req.port} - {1'b0, base_port};
    assign in_window = (diff[16] == 1'b0) && (diff[15:3] == 13'd0);
    assign offset    = diff[2:0];
    assign dlab      = state.line_ctrl[u16450_pkg::DLAB_POS];

    always_comb begin
        rd   = 8'd0;
        txv  = 1'b0;
        txb  = 8'd0;
        st_w = state;
        if (!req.is_write) begin
            case (offset)
                u16450_pkg::OFF_RBR_THR: rd = dlab ? state.divisor_low : 8'd0;
                u16450_pkg::OFF_IER:     rd = dlab ? state.divisor_high
                                                   : {4'd0, state.int_enable};
                u16450_pkg::OFF_IIR:     rd = {6'd0, state.int_ident};
                u16450_pkg::OFF_LCR:     rd = state.line_ctrl;
                u16450_pkg::OFF_MCR:     rd = {3'd0, state.modem_ctrl};
                u16450_pkg::OFF_LSR:     rd = u16450_pkg::LSR_IDLE;
                u16450_pkg::OFF_SCR:     rd = state.scratch;
                default:                 rd = 8'd0;
            endcase
        end else begin
            case (offset)
                u16450_pkg::OFF_RBR_THR: begin
                    if (dlab) begin
                        st_w.divisor_low = req.write_data;
                    end else begin
                        txv = 1'b1;
                        txb = req.write_data;
                    end
                end
                u16450_pkg::OFF_IER: begin
                    if (dlab) begin
                        st_w.divisor_high = req.write_data;
                    end else begin
                        st_w.int_enable = req.write_data[3:0];
                        st_w.int_ident  = req.write_data[u16450_pkg::IER_THRE_POS]
                                        ? u16450_pkg::IIR_THRE : u16450_pkg::IIR_NONE;
                    end
                end
                u16450_pkg::OFF_LCR: st_w.line_ctrl  = req.write_data;
                u16450_pkg::OFF_MCR: st_w.modem_ctrl = req.write_data[4:0];
                u16450_pkg::OFF_SCR: st_w.scratch    = req.write_data;
                default: ;
            endcase
        end
    end

    // Interrupt line follows the identification after the access
    always_comb begin
        pend_n = state.irq_pending;
        chg    = 1'b0;
        if (!state.irq_pending && st_w.int_ident[1]) begin
            pend_n = 1'b1;
            chg    = 1'b1;
        end else if (state.irq_pending && st_w.int_ident[0]) begin
            pend_n = 1'b0;
            chg    = 1'b1;
        end
    end

    always_comb begin
        state_next = state;
        rsp.read_data   = 8'd0;
        rsp.tx_valid    = 1'b0;
        rsp.tx_byte     = 8'd0;
        rsp.irq_level   = state.irq_pending;
        rsp.irq_changed = 1'b0;
        rsp.bad_access  = 1'b1;
        if (in_window) begin
            state_next             = st_w;
            state_next.irq_pending = pend_n;
            rsp.read_data   = rd;
            rsp.tx_valid    = txv;
            rsp.tx_byte     = txb;
            rsp.irq_level   = pend_n;
            rsp.irq_changed = chg;
            rsp.bad_access  = 1'b0;
        end
    end

endmodule

// ----- rtl/u16450_regfile.sv -----
module u16450_regfile (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [15:0]             cfg_wr_data,
    input  logic                    commit,
    input  u16450_pkg::uart_state_t state_next,
    output u16450_pkg::uart_state_t state,
    output logic [15:0]             base_port
);

    u16450_pkg::uart_state_t state_reg;
    logic [15:0]             base_port_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.divisor_low  <= 8'd0;
            state_reg.divisor_high <= 8'd0;
            state_reg.int_enable   <= 4'd0;
            state_reg.int_ident    <= u16450_pkg::IIR_NONE;
            state_reg.line_ctrl    <= 8'd0;
            state_reg.modem_ctrl   <= 5'd0;
            state_reg.scratch      <= 8'd0;
            state_reg.irq_pending  <= 1'b0;
        end else if (commit) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_port_reg <= u16450_pkg::BASE_PORT_RST;
        end else if (cfg_wr_en) begin
            base_port_reg <= cfg_wr_data;
        end
    end

    assign state     = state_reg;
    assign base_port = base_port_reg;

endmodule

// ----- rtl/uart_16450_register_file_unit.sv -----
// 16450-style UART register file, one byte-wide bus access per beat.
// Input channel (s_*): a read or write to an eight-port window starting at
// the base port held by the configuration register (cfg_wr_en/cfg_wr_data).
// The user must write it only while the block is idle; it is not enforced.
// Output channel (m_*): one result beat per input beat, in order: read data,
// transmit byte strobe, interrupt line level and change flag, and a flag for
// accesses outside the window (these change no state).
// Each accepted access is held in the input register, decoded, and captured
// in the result register that drives m_*. Throughput: one beat per cycle
// while m_ready is high, set by the single decode stage between the input
// register and the result register.
// Stalls: while m_ready is low the result register holds; the input register
// still takes one further beat, then s_ready drops until the result moves.
// Reset (aresetn low, synchronous): both stages empty, UART registers
// cleared, identification reads "no interrupt", base port back to 1016.
module uart_16450_register_file_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [15:0] s_port,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_byte,
    output logic        m_irq_level,
    output logic        m_irq_changed,
    output logic        m_bad_access
);

    // Input register
    logic                    in_valid_reg;
    logic                    in_valid_next;
    u16450_pkg::req_t        in_req_reg;
    // Result register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    u16450_pkg::rsp_t        out_rsp_reg;

    logic                    s_take;
    logic                    advance;
    u16450_pkg::uart_state_t state;
    u16450_pkg::uart_state_t state_next;
    u16450_pkg::rsp_t        rsp;
    logic [15:0]             base_port;

    // Advance the input beat whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: input captures on accept, result on advance; both hold otherwise
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_req_reg.is_write   <= s_req_type;
            in_req_reg.port       <= s_port;
            in_req_reg.write_data <= s_write_data;
        end
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    u16450_access u_access (
        .req        (in_req_reg),
        .base_port  (base_port),
        .state      (state),
        .state_next (state_next),
        .rsp        (rsp)
    );

    // UART state commits together with the result it produced
    u16450_regfile u_regfile (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .commit      (advance),
        .state_next  (state_next),
        .state       (state),
        .base_port   (base_port)
    );

    assign m_valid       = out_valid_reg;
    assign m_read_data   = out_rsp_reg.read_data;
    assign m_tx_valid    = out_rsp_reg.tx_valid;
    assign m_tx_byte     = out_rsp_reg.tx_byte;
    assign m_irq_level   = out_rsp_reg.irq_level;
    assign m_irq_changed = out_rsp_reg.irq_changed;
    assign m_bad_access  = out_rsp_reg.bad_access;

    // An access outside the window reports nothing but the line level
    a_bad_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bad_access |->
            !m_tx_valid && !m_irq_changed && (m_read_data == 8'd0))
        else $error("bad access carried data or side effects");

    // Reported line level matches the committed pending flag
    a_irq_track: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (state.irq_pending == out_rsp_reg.irq_level))
        else $error("irq level out of step with state");

    // Change flag reflects an actual toggle of the pending flag
    a_irq_change: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_rsp_reg.irq_changed ==
                     (state.irq_pending != $past(state.irq_pending))))
        else $error("irq change flag wrong");

    // Back-pressure only when both stages are occupied
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room available");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    // Access kinds on s_req_type
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Cycles without any beat moving before the run is declared hung
    localparam int unsigned IDLE_LIMIT       = 2000;
    // Receiver hold-off used to back the block up into its input
    localparam int unsigned LONG_HOLD_CYCLES = 80;
    localparam int unsigned LONG_HOLD_AFTER  = 250;
    // Keep the log readable when the block is badly broken
    localparam int unsigned REPORT_CAP       = 100;

    // One result beat, in the order the m_* fields are concatenated below
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_level;
        logic       irq_changed;
        logic       bad_access;
    } uart_result_t;

    // Shadow copy of the UART registers. Every accepted access is applied to
    // the shadow at once, and the result it must produce is queued until the
    // matching beat leaves the block.
    class uart_reg_shadow;
        int unsigned  base;
        logic [7:0]   divisor_lo;
        logic [7:0]   divisor_hi;
        logic [3:0]   ier;
        logic [1:0]   iir;
        logic [7:0]   lcr;
        logic [4:0]   mcr;
        logic [7:0]   scr;
        logic         irq;
        uart_result_t pending_results[$];
        int unsigned  mismatches;
        int unsigned  results_seen;
        int unsigned  accesses;
        int unsigned  outside_seen;
        int unsigned  tx_seen;
        int unsigned  irq_edges;

        function new();
            base         = u16450_pkg::BASE_PORT_RST;
            divisor_lo   = '0;
            divisor_hi   = '0;
            ier          = '0;
            iir          = u16450_pkg::IIR_NONE;
            lcr          = '0;
            mcr          = '0;
            scr          = '0;
            irq          = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            accesses     = 0;
            outside_seen = 0;
            tx_seen      = 0;
            irq_edges    = 0;
        endfunction

        function void set_base(logic [15:0] value);
            base = value;
        endfunction

        function void note_access(logic is_write, logic [15:0] port, logic [7:0] data);
            uart_result_t r;
            int unsigned  p;
            logic [2:0]   offs;
            logic         dlab;
            r    = '0;
            p    = port;
            dlab = lcr[u16450_pkg::DLAB_POS];
            accesses++;
            // Outside the window (which never wraps): flag it, touch nothing
            if (p < base || p - base > 7) begin
                r.irq_level  = irq;
                r.bad_access = 1'b1;
                outside_seen++;
                pending_results.push_back(r);
                return;
            end
            offs = 3'(p - base);
            if (is_write == REQ_READ) begin
                case (offs)
                    u16450_pkg::OFF_RBR_THR: r.read_data = dlab ? divisor_lo : 8'h00;
                    u16450_pkg::OFF_IER:     r.read_data = dlab ? divisor_hi : {4'h0, ier};
                    u16450_pkg::OFF_IIR:     r.read_data = {6'h00, iir};
                    u16450_pkg::OFF_LCR:     r.read_data = lcr;
                    u16450_pkg::OFF_MCR:     r.read_data = {3'b000, mcr};
                    u16450_pkg::OFF_LSR:     r.read_data = u16450_pkg::LSR_IDLE;
                    u16450_pkg::OFF_MSR:     r.read_data = 8'h00;
                    default:                 r.read_data = scr;
                endcase
            end else begin
                case (offs)
                    u16450_pkg::OFF_RBR_THR: begin
                        if (dlab) begin
                            divisor_lo = data;
                        end else begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = data;
                            tx_seen++;
                        end
                    end
                    u16450_pkg::OFF_IER: begin
                        if (dlab) begin
                            divisor_hi = data;
                        end else begin
                            ier = data[3:0];
                            iir = ier[u16450_pkg::IER_THRE_POS]
                                ? u16450_pkg::IIR_THRE : u16450_pkg::IIR_NONE;
                        end
                    end
                    u16450_pkg::OFF_LCR: lcr = data;
                    u16450_pkg::OFF_MCR: mcr = data[4:0];
                    u16450_pkg::OFF_SCR: scr = data;
                    default: ;
                endcase
            end
            // The line follows the identification after every access in the window
            if (!irq && (iir & u16450_pkg::IIR_THRE) != '0) begin
                irq = 1'b1;
                r.irq_changed = 1'b1;
            end else if (irq && (iir & u16450_pkg::IIR_NONE) != '0) begin
                irq = 1'b0;
                r.irq_changed = 1'b1;
            end
            if (r.irq_changed) irq_edges++;
            r.irq_level = irq;
            pending_results.push_back(r);
        endfunction

        function void check_result(uart_result_t got);
            uart_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display("%0t: result beat with no access waiting: actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            results_seen++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_CAP)
                    $display({"%0t: beat %0d mismatch: expected rd=%h txv=%b txb=%h irq=%b ",
                              "chg=%b bad=%b, actual rd=%h txv=%b txb=%h irq=%b chg=%b bad=%b"},
                             $time, results_seen, want.read_data, want.tx_valid, want.tx_byte,
                             want.irq_level, want.irq_changed, want.bad_access,
                             got.read_data, got.tx_valid, got.tx_byte,
                             got.irq_level, got.irq_changed, got.bad_access);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_req_type;
    logic [15:0] s_port;
    logic [7:0]  s_write_data;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_read_data;
    logic        m_tx_valid;
    logic [7:0]  m_tx_byte;
    logic        m_irq_level;
    logic        m_irq_changed;
    logic        m_bad_access;

    uart_result_t   out_beat;
    uart_reg_shadow shadow = new();

    // Stretches of back-to-back accesses with no sender gaps
    int unsigned burst_left;
    int unsigned bases_used;

    uart_16450_register_file_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_port        (s_port),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_tx_valid    (m_tx_valid),
        .m_tx_byte     (m_tx_byte),
        .m_irq_level   (m_irq_level),
        .m_irq_changed (m_irq_changed),
        .m_bad_access  (m_bad_access)
    );

    assign out_beat = {m_read_data, m_tx_valid, m_tx_byte, m_irq_level, m_irq_changed,
                       m_bad_access};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one, and bursts with none at all
    function automatic int unsigned next_gap();
        int unsigned pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(99, 0);
        if (pick < 3) begin
            burst_left = $urandom_range(30, 10);
            return 0;
        end
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(3, 1);
        if (pick < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Drop valid over a gap of length n; the next offer raises it again at its own edge
    task automatic pause_sender(input int unsigned n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Offer one access, hold it until taken, record it, then idle a while
    task automatic send_access(input logic is_write, input logic [15:0] port,
                               input logic [7:0] data);
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_req_type   <= is_write;
        s_port       <= port;
        s_write_data <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.note_access(is_write, port, data);
        pause_sender(next_gap());
    endtask

    // Stop offering and wait until every outstanding result has left
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (shadow.pending_results.size() != 0) @(posedge aclk);
        // let the two-stage pipe settle fully
        repeat (4) @(posedge aclk);
    endtask

    // Move the window; only ever done with the block empty
    task automatic write_base(input logic [15:0] value);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow.set_base(value);
        bases_used++;
    endtask

    task automatic poke(input logic is_write, input logic [2:0] offs, input logic [7:0] data);
        send_access(is_write, u16450_pkg::BASE_PORT_RST + 16'(offs), data);
    endtask

    // Hand-picked opening at the reset window: reads of all but LCR, writes to
    // all but IIR and MSR, divisor bank, transmit bytes, interrupt raised and
    // lowered, ignored and masked writes, ports on and past both window edges.
    task automatic directed_accesses();
        poke(REQ_READ,  u16450_pkg::OFF_RBR_THR, 8'hFF);
        poke(REQ_READ,  u16450_pkg::OFF_IER,     8'h00);
        poke(REQ_READ,  u16450_pkg::OFF_IIR,     8'h00);
        poke(REQ_READ,  u16450_pkg::OFF_LSR,     8'h00);
        poke(REQ_READ,  u16450_pkg::OFF_MSR,     8'h00);
        poke(REQ_WRITE, u16450_pkg::OFF_IER,     8'hFF);
        poke(REQ_READ,  u16450_pkg::OFF_IER,     8'h00);
        poke(REQ_READ,  u16450_pkg::OFF_IIR,     8'h00);
        poke(REQ_WRITE, u16450_pkg::OFF_RBR_THR, 8'h00);
        poke(REQ_WRITE, u16450_pkg::OFF_RBR_THR, 8'hFF);
        poke(REQ_WRITE, u16450_pkg::OFF_LCR,     8'h80);
        poke(REQ_WRITE, u16450_pkg::OFF_RBR_THR, 8'hA5);
        poke(REQ_WRITE, u16450_pkg::OFF_IER,     8'h5A);
        poke(REQ_READ,  u16450_pkg::OFF_RBR_THR, 8'h00);
        poke(REQ_READ,  u16450_pkg::OFF_IER,     8'h00);
        poke(REQ_WRITE, u16450_pkg::OFF_LCR,     8'h7F);
        poke(REQ_WRITE, u16450_pkg::OFF_IER,     8'h00);
        poke(REQ_WRITE, u16450_pkg::OFF_MCR,     8'hFF);
        poke(REQ_READ,  u16450_pkg::OFF_MCR,     8'h00);
        poke(REQ_WRITE, u16450_pkg::OFF_SCR,     8'hFF);
        poke(REQ_READ,  u16450_pkg::OFF_SCR,     8'h00);
        poke(REQ_WRITE, u16450_pkg::OFF_LSR,     8'hFF);
        send_access(REQ_READ,  16'd0,     8'h00);
        send_access(REQ_WRITE, 16'hFFFF,  8'hFF);
        send_access(REQ_READ,  u16450_pkg::BASE_PORT_RST - 16'd1, 8'h00);
        send_access(REQ_WRITE, u16450_pkg::BASE_PORT_RST + 16'd8, 8'h3C);
    endtask

    // Mostly inside the window, some just past either edge, the rest anywhere
    task automatic random_access();
        int unsigned lo;
        int unsigned hi;
        int unsigned p;
        int unsigned pick;
        lo   = shadow.base;
        hi   = (lo + 7 > 65535) ? 65535 : lo + 7;
        pick = $urandom_range(99, 0);
        if (pick < 78) begin
            p = $urandom_range(hi, lo);
        end else if (pick < 88) begin
            if (lo > 0 && ($urandom_range(1, 0) == 1 || hi == 65535)) p = lo - 1;
            else p = hi + 1;
        end else begin
            p = $urandom_range(65535, 0);
        end
        send_access(1'($urandom_range(1, 0)), 16'(p), 8'($urandom_range(255, 0)));
    endtask

    task automatic run_random(input int unsigned n, input bit pause_midway);
        for (int unsigned i = 0; i < n; i++) begin
            // sender waits out the whole pipe once, mid-phase
            if (pause_midway && i == n / 2) drain();
            random_access();
        end
    endtask

    // Result side: random stalls, stall runs and ready runs, plus one long
    // hold-off so the block backs up into its input.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned ready_left;
        int unsigned pick;
        bit          long_hold_done;
        stall_left     = 0;
        ready_left     = 0;
        long_hold_done = 1'b0;
        m_ready        = 1'b0;
        forever begin
            @(negedge aclk);
            if (!long_hold_done && shadow.results_seen >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall_left     = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (ready_left > 0) begin
                ready_left--;
                m_ready <= 1'b1;
            end else begin
                pick = $urandom_range(99, 0);
                if (pick < 4) stall_left = $urandom_range(30, 8);
                else if (pick < 10) ready_left = $urandom_range(60, 20);
                m_ready <= (pick >= 35);
            end
        end
    end

    // Sample result beats at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) shadow.check_result(out_beat);
    end

    // Declare the run hung when no beat moves on either side for too long
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("uart_16450_register_file_unit verification failed");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = u16450_pkg::BASE_PORT_RST;
        s_valid      = 1'b0;
        s_req_type   = REQ_READ;
        s_port       = '0;
        s_write_data = '0;
        burst_left   = 0;
        bases_used   = 1;
        // hold reset low, then release it on a falling edge
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        directed_accesses();
        // window at the very bottom of the port space
        write_base(16'd0);
        run_random(120, 1'b0);
        // highest legal base: window ends exactly at the top port
        write_base(16'd65528);
        run_random(120, 1'b0);
        // base above range: window is cut short at the top port
        write_base(16'd65533);
        run_random(40, 1'b0);
        write_base(16'($urandom_range(65527, 1)));
        run_random(130, 1'b1);
        write_base(u16450_pkg::BASE_PORT_RST);
        run_random(140, 1'b0);
        drain();
        repeat (6) @(posedge aclk);

        $display("Covered %0d accesses, %0d outside the window, %0d transmit bytes,",
                 shadow.accesses, shadow.outside_seen, shadow.tx_seen);
        $display("%0d irq edges, over %0d window positions including both ends of the port space",
                 shadow.irq_edges, bases_used);
        if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
            $display("uart_16450_register_file_unit verification clean");
        end else begin
            $display("%0d mismatches, %0d results outstanding", shadow.mismatches,
                     shadow.pending_results.size());
            $display("uart_16450_register_file_unit verification failed");
        end
        $finish;
    end

endmodule
